// ----- src/pmkv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix-match key/value table: shared package
// Types, sizes, request codes and helper functions used by the table cells
// and the top level.
// ----------------------------------------------------------------------------
package pmkv_pkg;

  // Table geometry.
  localparam int ENTRIES   = 16;
  localparam int KEY_BYTES = 8;
  localparam int KEY_W     = KEY_BYTES * 8;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W    = $clog2(ENTRIES + 1);

  // Request opcodes.
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Capacity after reset.
  localparam logic [4:0] CAPACITY_RESET = 5'd16;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE
  } state_t;

  // Input request payload.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] query_key;
    logic [3:0]  key_len;
    logic [31:0] value_handle;
    logic [15:0] value_len;
  } in_req_t;

  // Result payload.
  typedef struct packed {
    logic        ok;
    logic [3:0]  entry_index;
    logic [31:0] found_value;
    logic [15:0] found_value_len;
    logic [3:0]  found_key_len;
  } out_rsp_t;

  // One stored table entry.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [3:0]       key_len;
    logic [31:0]      value;
    logic [15:0]      value_len;
  } entry_t;

  // Priority chain passed from each cell to the next higher one.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } chain_t;

  // Byte mask covering the first key_len bytes of a key.
  function automatic logic [KEY_W-1:0] byte_mask(input logic [3:0] key_len);
    logic [KEY_W-1:0] mask;
    mask = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (4'(b) < key_len) begin
        mask[b*8 +: 8] = 8'hFF;
      end
    end
    return mask;
  endfunction

  // Key length clipped to the stored key size.
  function automatic logic [3:0] clip_key_len(input logic [3:0] key_len);
    logic [3:0] clipped;
    clipped = (key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_len;
    return clipped;
  endfunction

endpackage

// ----- src/pmkv_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix-match key/value table: table cell
// Holds one entry, registers its prefix compare against the query key and
// takes part in the lowest-index-wins priority chain.
// ----------------------------------------------------------------------------
module pmkv_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cell_valid,
  input  logic                      cmp_en,
  input  logic [pmkv_pkg::KEY_W-1:0] query_key,
  input  logic [pmkv_pkg::IDX_W-1:0] cell_idx,
  input  logic                      wr_en,
  input  pmkv_pkg::entry_t          wr_entry,
  input  pmkv_pkg::chain_t          chain_in,
  output pmkv_pkg::chain_t          chain_out
);

  import pmkv_pkg::*;

  entry_t entry_r;
  logic   match_r;
  logic   match_nxt;

  // Prefix compare over the stored key length; only filled slots may match.
  assign match_nxt = cell_valid &&
                     (((entry_r.key ^ query_key) & byte_mask(entry_r.key_len)) == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (cmp_en) begin
      match_r <= match_nxt;
    end
  end

  // Entry storage; the contents are only read once written after a clear.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_entry;
    end
  end

  // Take over the chain if this is the first matching cell from below.
  always_comb begin
    chain_out = chain_in;
    if (match_r && !chain_in.hit) begin
      chain_out.hit   = 1'b1;
      chain_out.idx   = cell_idx;
      chain_out.entry = entry_r;
    end
  end

endmodule

// ----- src/prefix_match_key_value_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix-match key/value table
// Small key/value table built as a row of entry cells, with put, get and
// clear requests and a writable capacity limit.
// ----------------------------------------------------------------------------
// Each request passes through ST_MATCH and ST_RESOLVE: in ST_MATCH every cell registers its
// prefix compare against the query key, in ST_RESOLVE the priority chain
// through the row of cells picks the lowest matching slot, the table is
// written and the result is loaded into the output register. A new request
// is also taken in ST_RESOLVE, so a following request is accepted as the current
// one finishes while the output side keeps up; a result still waiting in the
// output register holds ST_RESOLVE. Clear only resets the fill count,
// so no clearing pass is needed after reset or clear. The capacity register
// is written through the cfg_ port and takes effect on the next put.
// ----------------------------------------------------------------------------
module prefix_match_key_value_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pmkv_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output pmkv_pkg::out_rsp_t out_rsp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);

  import pmkv_pkg::*;

  state_t            state_r, state_nxt;
  in_req_t           req_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [4:0]        capacity_r;
  logic              out_valid_r, out_valid_nxt;
  out_rsp_t          out_rsp_r, out_rsp_nxt;

  logic                req_load;
  logic                cmp_en;
  logic                can_finish;
  logic                wr_do;
  logic [IDX_W-1:0]    wr_idx;
  entry_t              wr_entry;
  logic                room;
  logic [IDX_W+3:0]    idx_ext;
  logic [ENTRIES-1:0]  cell_valid;
  logic [ENTRIES-1:0]  wr_sel;
  chain_t              chain [ENTRIES+1];

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_valid) begin
      capacity_r <= cfg_data;
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (req_load) begin
      req_r <= in_req;
    end
  end

  // Control state, fill count and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESOLVE && can_finish) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  // Row of table cells with the priority chain running from slot 0 upwards.
  assign chain[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign cell_valid[i] = (FILL_W'(i) < fill_r);
    assign wr_sel[i]     = wr_do && (wr_idx == IDX_W'(i));

    pmkv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_valid (cell_valid[i]),
      .cmp_en     (cmp_en),
      .query_key  (req_r.query_key[KEY_W-1:0]),
      .cell_idx   (IDX_W'(i)),
      .wr_en      (wr_sel[i]),
      .wr_entry   (wr_entry),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1])
    );
  end

  // Room for a new entry under both the capacity register and the table size.
  assign room = (32'(fill_r) < 32'(capacity_r)) && (32'(fill_r) < ENTRIES);

  // Data written by a put.
  always_comb begin
    wr_entry.key       = req_r.query_key[KEY_W-1:0];
    wr_entry.key_len   = clip_key_len(req_r.key_len);
    wr_entry.value     = req_r.value_handle;
    wr_entry.value_len = req_r.value_len;
  end

  assign can_finish = !out_valid_r || out_ready;

  // Sequencer, table update and result.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = '0;
    in_ready      = 1'b0;
    cmp_en        = 1'b0;
    wr_do         = 1'b0;
    wr_idx        = chain[ENTRIES].idx;
    idx_ext       = '0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmp_en    = 1'b1;
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (can_finish) begin
          in_ready      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = in_valid ? ST_MATCH : ST_IDLE;
          case (req_r.opcode)
            OP_PUT: begin
              if (chain[ENTRIES].hit) begin
                wr_do = 1'b1;
              end else if (room) begin
                wr_do    = 1'b1;
                wr_idx   = fill_r[IDX_W-1:0];
                fill_nxt = fill_r + FILL_W'(1);
              end
              if (wr_do) begin
                idx_ext                 = {4'b0, wr_idx};
                out_rsp_nxt.ok          = 1'b1;
                out_rsp_nxt.entry_index = idx_ext[3:0];
              end
            end
            OP_GET: begin
              if (chain[ENTRIES].hit) begin
                idx_ext                     = {4'b0, chain[ENTRIES].idx};
                out_rsp_nxt.ok              = 1'b1;
                out_rsp_nxt.entry_index     = idx_ext[3:0];
                out_rsp_nxt.found_value     = chain[ENTRIES].entry.value;
                out_rsp_nxt.found_value_len = chain[ENTRIES].entry.value_len;
                out_rsp_nxt.found_key_len   = chain[ENTRIES].entry.key_len;
              end
            end
            OP_CLEAR: begin
              fill_nxt       = '0;
              out_rsp_nxt.ok = 1'b1;
            end
            default: begin
              out_rsp_nxt = '0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign req_load  = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the prefix-match key/value table
// Drives put, get and clear requests and capacity writes through their
// valid/ready channels, keeps its own shadow copy of the table to predict
// each response, and checks every response field against that prediction.
// Both sides stall at random, apart from one long phase without stalls.
// ----------------------------------------------------------------------------
module tb;
  import pmkv_pkg::*;

  // Opcode value that the block does not define.
  localparam logic [1:0] OP_UNDEF = 2'd3;

  localparam int RANDOM_ITEMS = 1125;
  localparam int STALL_PCT    = 31;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_req_t    in_req = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_rsp_t   out_rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = '0;

  // Shadow copy of the table contents and the capacity register.
  logic [63:0] slot_key [ENTRIES];
  logic [3:0]  slot_klen [ENTRIES];
  logic [31:0] slot_value [ENTRIES];
  logic [15:0] slot_vlen [ENTRIES];
  int unsigned fill_shadow = 0;
  logic [4:0]  capacity_shadow = CAPACITY_RESET;

  out_rsp_t    awaited_responses [$];
  out_rsp_t    expected_rsp;
  logic [63:0] key_pool [8];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  bit          stall_enable = 1'b1;

  prefix_match_key_value_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Mask over the first klen key bytes.
  function automatic logic [63:0] prefix_mask(input logic [3:0] klen);
    if (klen >= 4'd8) begin
      return '1;
    end
    return (64'd1 << (int'(klen) * 8)) - 64'd1;
  endfunction

  // Lowest filled slot whose stored prefix matches the key, or -1.
  function automatic int find_slot(input logic [63:0] key);
    for (int i = 0; i < int'(fill_shadow); i++) begin
      if (((slot_key[i] ^ key) & prefix_mask(slot_klen[i])) == '0) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and returns the response it gives.
  function automatic out_rsp_t apply_table_request(input in_req_t r);
    out_rsp_t    rsp;
    int          slot;
    int unsigned limit;
    logic [3:0]  klen;
    rsp = '0;
    klen = (r.key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : r.key_len;
    limit = (capacity_shadow > ENTRIES) ? ENTRIES : capacity_shadow;
    case (r.opcode)
      OP_PUT: begin
        slot = find_slot(r.query_key);
        if (slot < 0 && fill_shadow < limit) begin
          slot = int'(fill_shadow);
          fill_shadow++;
        end
        if (slot >= 0) begin
          slot_key[slot]   = r.query_key;
          slot_klen[slot]  = klen;
          slot_value[slot] = r.value_handle;
          slot_vlen[slot]  = r.value_len;
          rsp.ok = 1'b1;
          rsp.entry_index = 4'(slot);
        end
      end
      OP_GET: begin
        slot = find_slot(r.query_key);
        if (slot >= 0) begin
          rsp.ok = 1'b1;
          rsp.entry_index = 4'(slot);
          rsp.found_value = slot_value[slot];
          rsp.found_value_len = slot_vlen[slot];
          rsp.found_key_len = slot_klen[slot];
        end
      end
      OP_CLEAR: begin
        fill_shadow = 0;
        rsp.ok = 1'b1;
      end
      default: begin
        rsp = '0;
      end
    endcase
    return rsp;
  endfunction

  function automatic in_req_t mk_req(input logic [1:0] op, input logic [63:0] key,
                                     input logic [3:0] klen, input logic [31:0] val,
                                     input logic [15:0] vlen);
    in_req_t r;
    r.opcode = op;
    r.query_key = key;
    r.key_len = klen;
    r.value_handle = val;
    r.value_len = vlen;
    return r;
  endfunction

  // Random request, mostly keyed from the phase's key pool so that prefixes collide.
  function automatic in_req_t random_request();
    in_req_t     r;
    int          roll;
    int          kept;
    logic [63:0] pool_key;
    r.query_key = {$urandom, $urandom};
    r.value_handle = $urandom;
    r.value_len = 16'($urandom);
    roll = $urandom_range(99);
    if (roll < 6) begin
      r.key_len = 4'd0;
    end else if (roll < 16) begin
      r.key_len = 4'($urandom_range(15, 9));
    end else begin
      r.key_len = 4'($urandom_range(8, 1));
    end
    roll = $urandom_range(99);
    if (roll < 45) begin
      r.opcode = OP_PUT;
    end else if (roll < 95) begin
      r.opcode = OP_GET;
    end else if (roll < 97) begin
      r.opcode = OP_CLEAR;
    end else begin
      r.opcode = OP_UNDEF;
    end
    if ($urandom_range(99) < 75) begin
      pool_key = key_pool[$urandom_range(7)];
      kept = $urandom_range(1) ? 8 : $urandom_range(8);
      for (int b = 0; b < kept; b++) begin
        r.query_key[b*8 +: 8] = pool_key[b*8 +: 8];
      end
    end
    return r;
  endfunction

  // Sends one request, then records its predicted response once it is taken.
  task automatic issue_request(input in_req_t r);
    @(negedge clk);
    while (stall_enable && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (!in_ready);
    awaited_responses.push_back(apply_table_request(r));
  endtask

  // Holds the sender back until every outstanding response has come.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_responses.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    wait_for_drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    capacity_shadow = cap;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Empty table, undefined opcode and clear.
  task automatic test_empty_and_undefined();
    issue_request(mk_req(OP_GET, 64'd0, 4'd0, 32'd0, 16'd0));
    issue_request(mk_req(OP_UNDEF, '1, 4'hF, '1, '1));
    issue_request(mk_req(OP_CLEAR, '1, 4'hF, '1, '1));
    issue_request(mk_req(OP_GET, '1, 4'hF, '1, '1));
  endtask

  // Long key lengths, single-byte and empty prefixes, and updates in place.
  task automatic test_prefix_hits_and_update();
    issue_request(mk_req(OP_PUT, '1, 4'hF, '1, '1));
    issue_request(mk_req(OP_PUT, 64'd0, 4'd8, 32'd0, 16'd0));
    issue_request(mk_req(OP_GET, '1, 4'd0, 32'd0, 16'd0));
    issue_request(mk_req(OP_GET, 64'd0, 4'd0, 32'd0, 16'd0));
    issue_request(mk_req(OP_PUT, 64'h1122_3344_5566_77AB, 4'd1, 32'hA5A5_5A5A, 16'h1234));
    issue_request(mk_req(OP_GET, 64'hFFFF_FFFF_FFFF_FFAB, 4'd0, 32'd0, 16'd0));
    issue_request(mk_req(OP_PUT, 64'h5A5A_5A5A_5A5A_5A5A, 4'd0, 32'h0BAD_F00D, 16'h8000));
    issue_request(mk_req(OP_GET, 64'h0000_0000_0000_1234, 4'd0, 32'd0, 16'd0));
    issue_request(mk_req(OP_PUT, '1, 4'd4, 32'h1357_9BDF, 16'h0001));
    issue_request(mk_req(OP_GET, 64'h0000_0000_FFFF_FFFF, 4'd0, 32'd0, 16'd0));
    issue_request(mk_req(OP_CLEAR, 64'd0, 4'd0, 32'd0, 16'd0));
    issue_request(mk_req(OP_GET, 64'h0000_0000_FFFF_FFFF, 4'd0, 32'd0, 16'd0));
  endtask

  // Zero capacity, a full table, out-of-range capacity, and capacity below the fill count.
  task automatic test_capacity_limits();
    write_capacity(5'd0);
    issue_request(mk_req(OP_PUT, 64'h0101, 4'd3, 32'd1, 16'd1));
    issue_request(mk_req(OP_GET, 64'h0101, 4'd0, 32'd0, 16'd0));
    write_capacity(5'd1);
    issue_request(mk_req(OP_PUT, 64'hAAAA, 4'd8, 32'd2, 16'd2));
    issue_request(mk_req(OP_PUT, 64'hBBBB, 4'd8, 32'd3, 16'd3));
    issue_request(mk_req(OP_PUT, 64'hAAAA, 4'd8, 32'd4, 16'd4));
    write_capacity(5'd31);
    issue_request(mk_req(OP_PUT, 64'hBBBB, 4'd8, 32'd5, 16'd5));
    issue_request(mk_req(OP_PUT, 64'hCCCC, 4'd2, 32'd6, 16'd6));
    write_capacity(5'd1);
    issue_request(mk_req(OP_PUT, 64'hFFFF_CCCC, 4'd6, 32'd7, 16'd7));
    issue_request(mk_req(OP_PUT, 64'hDDDD, 4'd8, 32'd8, 16'd8));
    issue_request(mk_req(OP_GET, 64'hBBBB, 4'd0, 32'd0, 16'd0));
    write_capacity(5'd16);
  endtask

  // Phases of random traffic, each with its own capacity and key pool.
  task automatic test_random_traffic();
    int          sent;
    int          phase;
    int          kept;
    int          burst;
    logic [63:0] base_key;
    logic [4:0]  cap;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      stall_enable = (phase != 2);
      case (phase % 7)
        0: cap = 5'd16;
        1: cap = 5'd0;
        2: cap = 5'd31;
        3: cap = 5'd1;
        4: cap = 5'd17;
        default: cap = 5'($urandom_range(31));
      endcase
      write_capacity(cap);
      if ($urandom_range(1)) begin
        issue_request(mk_req(OP_CLEAR, {$urandom, $urandom}, 4'($urandom), $urandom,
                             16'($urandom)));
      end
      // Pool keys share a random number of low bytes with a common base.
      base_key = {$urandom, $urandom};
      for (int k = 0; k < 8; k++) begin
        key_pool[k] = base_key;
        kept = $urandom_range(7);
        for (int b = kept; b < 8; b++) begin
          key_pool[k][b*8 +: 8] = 8'($urandom);
        end
      end
      // The last phase is cut short so that the total stays on target.
      burst = $urandom_range(140, 60);
      if (burst > RANDOM_ITEMS - sent) begin
        burst = RANDOM_ITEMS - sent;
      end
      repeat (burst) begin
        issue_request(random_request());
        sent++;
        if ($urandom_range(99) < 3) begin
          wait_for_drain();
        end
      end
      phase++;
    end
    stall_enable = 1'b1;
  endtask

  // Result side back-pressure.
  always @(negedge clk) begin
    out_ready <= !stall_enable || ($urandom_range(99) >= STALL_PCT);
  end

  // Response checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_responses.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual 0x%0h", $time, out_rsp);
        mismatch_count++;
      end else begin
        expected_rsp = awaited_responses.pop_front();
        check_field("ok", expected_rsp.ok, out_rsp.ok);
        check_field("entry_index", expected_rsp.entry_index, out_rsp.entry_index);
        check_field("found_value", expected_rsp.found_value, out_rsp.found_value);
        check_field("found_value_len", expected_rsp.found_value_len,
                    out_rsp.found_value_len);
        check_field("found_key_len", expected_rsp.found_key_len,
                    out_rsp.found_key_len);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_capacity(5'd16);
    test_empty_and_undefined();
    test_prefix_hits_and_update();
    test_capacity_limits();
    test_random_traffic();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
